[src/assert_macros.svh]
// Assertion macros for the prime field arithmetic unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[src/pfau_pkg.sv]
// Shared types and constants for the prime field arithmetic unit
`timescale 1ns / 1ps
package pfau_pkg;
  localparam int PRIME_BITS_DEF = 31;
  localparam int ELEM_BITS = 31;
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_NEG = 3'd2;
  localparam logic [2:0] CMD_MUL = 3'd3;
  localparam logic [2:0] CMD_INV = 3'd4;
  localparam logic [2:0] CMD_DIV = 3'd5;
  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_ZERO = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands
    logic do_mul;    // one multiply bit step
    logic mul_init;  // start multiply with a, b
    logic mul_inv;   // start multiply with a, inverse
    logic inv_init;  // start euclid
    logic div_step;  // one division bit step
    logic div_start; // start quotient of u / v
    logic euc_update;// apply quotient
    logic fin_inv;   // fold cofactor into range
    logic set_simple;// compute add/sub/neg/checks
  } pfau_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic v_zero;
  } pfau_sts_t;
endpackage

[src/prime_field_arithmetic_unit_core.sv]
// Top level of the prime field arithmetic unit
// Add/sub/neg finish in the check state; multiply then runs its shift-add bit steps.
// Inverse runs k euclid quotient steps, each a W-bit restoring division (W = 31 by default);
// divide runs the inverse of b, then a multiply by a. One command in flight at a time; the next
// input beat can be taken in the cycle after the result beat; the result holds until taken.
// Synchronous active-high reset returns to idle and loads modulus 32003.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module prime_field_arithmetic_unit_core #(
  parameter int PRIME_BITS = pfau_pkg::PRIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            cmd,
  input  logic [30:0]           operand_a,
  input  logic [30:0]           operand_b,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [30:0]           result,
  output logic [1:0]            error_code,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [PRIME_BITS-1:0] prime_modulus
);
  import pfau_pkg::*;
  logic [PRIME_BITS-1:0] prime;
  pfau_cmd_t ctl;
  pfau_sts_t sts;
  logic [2:0] cmd_q;
  logic [30:0] res;
  logic [1:0] err;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) prime <= PRIME_BITS'(32003);
    else if (cfg_valid) prime <= prime_modulus;
  end

  pfau_control u_ctl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd_q, .err, .sts, .ctl
  );
  pfau_datapath #(.PRIME_BITS(PRIME_BITS)) u_dp (
    .clk, .cmd, .operand_a, .operand_b, .prime, .ctl, .sts, .cmd_q, .res, .err
  );

  assign result = res;
  assign error_code = err;

  `ASSERT_IMPL(a_no_both, clk, rst, out_valid, in_stall)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid)
endmodule

[src/pfau_datapath.sv]
// Datapath: operand registers, shift-add multiplier, restoring divider, euclid cofactors
`timescale 1ns / 1ps
module pfau_datapath #(
  parameter int PRIME_BITS = pfau_pkg::PRIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic [2:0]                  cmd,
  input  logic [30:0]                 operand_a,
  input  logic [30:0]                 operand_b,
  input  logic [PRIME_BITS-1:0]       prime,
  input  pfau_pkg::pfau_cmd_t         ctl,
  output pfau_pkg::pfau_sts_t         sts,
  output logic [2:0]                  cmd_q,
  output logic [30:0]                 res,
  output logic [1:0]                  err
);
  import pfau_pkg::*;
  localparam int W = (PRIME_BITS > ELEM_BITS) ? PRIME_BITS : ELEM_BITS;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] a, b, p, u, v, q, rem, dvd, mr, mcand, mb;
  logic signed [W+1:0] c1, c2;
  logic [CW-1:0] mcnt, dcnt;
  logic [W:0] s2, s3, rsh;
  logic [2*W+1:0] qc2;

  assign sts.mul_done = (mcnt == '0);
  assign sts.div_done = (dcnt == '0);
  assign sts.v_zero = (v == '0);

  // modular doubling then conditional add; divider shift and quotient-cofactor product
  always_comb begin
    s2 = {1'b0, mr} + {1'b0, mr};
    if (s2 >= {1'b0, p}) s2 = s2 - {1'b0, p};
    s3 = s2 + {1'b0, mcand};
    if (s3 >= {1'b0, p}) s3 = s3 - {1'b0, p};
    rsh = {rem, dvd[W-1]};
    qc2 = $signed({1'b0, q}) * c2;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
      a <= W'(operand_a);
      b <= W'(operand_b);
      p <= W'(prime);
    end
    if (ctl.set_simple) begin
      logic ub;
      logic [W:0] t;
      logic [30:0] r_v;
      logic [1:0] e_v;
      ub = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB) || (cmd_q == CMD_MUL) ||
           (cmd_q == CMD_DIV);
      t = '0;
      r_v = '0;
      e_v = ERR_OK;
      if (cmd_q <= CMD_DIV && (a >= p || (ub && b >= p))) begin
        e_v = ERR_RANGE;
      end else begin
        case (cmd_q)
          CMD_ADD: begin
            t = {1'b0, a} + {1'b0, b};
            if (t >= {1'b0, p}) t = t - {1'b0, p};
            r_v = t[30:0];
          end
          CMD_SUB: begin
            t = (a >= b) ? {1'b0, a - b} : {1'b0, a} + {1'b0, p - b};
            r_v = t[30:0];
          end
          CMD_NEG: r_v = (a == '0) ? '0 : 31'(p - a);
          CMD_INV: if (a == '0) e_v = ERR_ZERO;
          CMD_DIV: if (a != '0 && b == '0) e_v = ERR_ZERO;
          default: ;
        endcase
      end
      res <= r_v;
      err <= e_v;
    end
    if (ctl.mul_init || ctl.mul_inv) begin
      mr <= '0;
      mcand <= a;
      mb <= ctl.mul_init ? b : ((c1 < 0) ? W'(c1 + $signed({2'b0, p})) : W'(c1));
      mcnt <= CW'(PRIME_BITS);
    end else if (ctl.do_mul) begin
      mr <= mb[PRIME_BITS-1] ? s3[W-1:0] : s2[W-1:0];
      mb <= mb << 1;
      mcnt <= mcnt - 1'b1;
    end
    if (ctl.inv_init) begin
      u <= (cmd_q == CMD_INV) ? a : b;
      v <= p;
      c1 <= (W+2)'(1);
      c2 <= '0;
    end
    if (ctl.div_start) begin
      dvd <= u;
      rem <= '0;
      q <= '0;
      dcnt <= CW'(W);
    end else if (ctl.div_step) begin
      if (rsh >= {1'b0, v}) begin
        rem <= W'(rsh - {1'b0, v});
        q <= {q[W-2:0], 1'b1};
      end else begin
        rem <= rsh[W-1:0];
        q <= {q[W-2:0], 1'b0};
      end
      dvd <= dvd << 1;
      dcnt <= dcnt - 1'b1;
    end
    if (ctl.euc_update) begin
      u <= v;
      v <= rem;
      c1 <= c2;
      c2 <= c1 - (W+2)'(qc2);
    end
    if (ctl.fin_inv) begin
      res <= 31'((c1 < 0) ? W'(c1 + $signed({2'b0, p})) : W'(c1));
    end
    if (ctl.do_mul && mcnt == CW'(1)) res <= 31'(mb[PRIME_BITS-1] ? s3 : s2);
  end
endmodule

[src/pfau_control.sv]
// Controller: sequences the checks, euclid loop and multiply
`timescale 1ns / 1ps
module pfau_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic [2:0]          cmd_q,
  input  logic [1:0]          err,
  input  pfau_pkg::pfau_sts_t sts,
  output pfau_pkg::pfau_cmd_t ctl
);
  import pfau_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_CHK = 3'd1, S_DIVS = 3'd2,
                         S_DIV = 3'd3, S_UPD = 3'd4, S_MUL = 3'd5, S_OUT = 3'd6;
  logic [2:0] state, state_next;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    ctl = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        ctl.load = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        ctl.set_simple = 1'b1;
        state_next = S_OUT;
        // decide from the registered operands via err preview next cycle
        if (cmd_q == CMD_MUL || cmd_q == CMD_INV || cmd_q == CMD_DIV) state_next = S_DIVS;
      end
      S_DIVS: begin
        // err and res now hold the simple outcome
        if (err != ERR_OK) state_next = S_OUT;
        else if (cmd_q == CMD_MUL) begin
          ctl.mul_init = 1'b1;
          state_next = S_MUL;
        end else begin
          ctl.inv_init = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (sts.v_zero) begin
          if (cmd_q == CMD_INV) begin
            ctl.fin_inv = 1'b1;
            state_next = S_OUT;
          end else begin
            ctl.mul_inv = 1'b1;
            state_next = S_MUL;
          end
        end else begin
          ctl.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          ctl.euc_update = 1'b1;
          state_next = S_UPD;
        end else ctl.div_step = 1'b1;
      end
      S_MUL: begin
        if (sts.mul_done) state_next = S_OUT;
        else ctl.do_mul = 1'b1;
      end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
